@@ hw/rtl/rrtq_pkg.sv @@
package rrtq_pkg;

	localparam int unsigned IDX_W  = 31;
	localparam int unsigned INST_W = 63;
	localparam int unsigned NUM_W  = 31;
	localparam int unsigned TPS_W  = 32;
	localparam int unsigned TD_W   = 63;   // ticks_per_second * rate_den
	localparam int unsigned PROD_W = 94;   // widest exact product
	localparam int unsigned ADDR_W = 4;

	// front divider: one quotient bit per stage, back divider likewise
	localparam int unsigned FDIV_N = 31;
	localparam int unsigned BDIV_N = 63;

	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;
	localparam logic [QCNT_W-1:0] QCNT_FULL = 3'd4;

	localparam logic [1:0] REG_RATE_NUM = 2'd0;
	localparam logic [1:0] REG_RATE_DEN = 2'd1;
	localparam logic [1:0] REG_TPS      = 2'd2;
	localparam logic [1:0] REG_NFRAMES  = 2'd3;

	localparam logic [NUM_W-1:0] RST_RATE_NUM = 31'd24;
	localparam logic [NUM_W-1:0] RST_RATE_DEN = 31'd1;
	localparam logic [TPS_W-1:0] RST_TPS      = 32'd705600000;
	localparam logic [NUM_W-1:0] RST_NFRAMES  = 31'd0;
	localparam logic [TD_W-1:0]  RST_TICK_DEN = 63'd705600000;

	typedef struct packed {
		logic [NUM_W-1:0] rate_num;
		logic [NUM_W-1:0] rate_den;
		logic [TPS_W-1:0] tps;
		logic [NUM_W-1:0] n_frames;
		logic [TD_W-1:0]  tick_den;
	} cfg_t;

	typedef struct packed {
		logic              valid_res;
		logic [IDX_W-1:0]  frame_index;
		logic [INST_W-1:0] frame_instant;
		logic              instant_saturated;
	} res_t;

	typedef struct packed {
		logic              empty;
		logic              pos;
		logic              ovf;
		logic [PROD_W-1:0] rem;
		logic [IDX_W-1:0]  quo;
	} fdiv_t;

	typedef struct packed {
		logic              empty;
		logic              zero;
		logic              ovf;
		logic [IDX_W-1:0]  idx;
		logic [PROD_W-1:0] rem;
		logic [INST_W-1:0] quo;
	} bdiv_t;

endpackage

@@ hw/rtl/rrtq_queue.sv @@
module rrtq_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rrtq_pkg::res_t din,
	output logic          full,
	input  logic          pop,
	output rrtq_pkg::res_t dout,
	output logic          empty
);

	rrtq_pkg::res_t mem_q [0:3];
	logic [rrtq_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [rrtq_pkg::QCNT_W-1:0] cnt_q;
	logic wr, rd;

	assign full  = (cnt_q == rrtq_pkg::QCNT_FULL);
	assign empty = (cnt_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + rrtq_pkg::QCNT_W'(wr) - rrtq_pkg::QCNT_W'(rd);
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rrtq_pkg::QCNT_FULL) else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != rrtq_pkg::QCNT_FULL && cnt_q != '0) |-> (wptr_q != rptr_q))
		else $error("queue pointers disagree with count");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("queue count slip");
`endif

endmodule

@@ hw/rtl/rrtq_front.sv @@
module rrtq_front (
	input  logic                clk,
	input  logic                arst_n,
	input  rrtq_pkg::cfg_t      cfg,
	input  logic                push,
	input  logic signed [63:0]  time_ticks,
	output logic                full,
	output logic                mq_push,
	output rrtq_pkg::res_t      mq_item,
	input  logic                mq_full
);

	localparam int unsigned N = rrtq_pkg::FDIV_N;

	logic adv;
	logic vld_s1, vld_s2;
	logic [N:0] dv_vld_s;
	logic empty_s1, pos_s1, empty_s2, pos_s2;
	logic [62:0] plo_s1;
	logic [61:0] phi_s1;
	logic [rrtq_pkg::PROD_W-1:0] n_s2;
	rrtq_pkg::fdiv_t dv_s [0:N];
	logic [rrtq_pkg::IDX_W-1:0] last, idx;

	assign adv     = !dv_vld_s[N] || !mq_full;
	assign full    = !adv;
	assign mq_push = dv_vld_s[N] && !mq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			dv_vld_s <= '0;
		end else if (adv) begin
			vld_s1   <= push;
			vld_s2   <= vld_s1;
			dv_vld_s <= {dv_vld_s[N-1:0], vld_s2};
		end
	end

	// split the 63 x 31 product into two halves, sum them one stage later
	always_ff @(posedge clk) begin
		if (adv) begin
			empty_s1 <= (cfg.n_frames == '0);
			pos_s1   <= (time_ticks != '0) && !time_ticks[63] && (cfg.rate_num != '0);
			plo_s1   <= 63'(time_ticks[31:0]) * 63'(cfg.rate_num);
			phi_s1   <= 62'(time_ticks[62:32]) * 62'(cfg.rate_num);
			empty_s2 <= empty_s1;
			pos_s2   <= pos_s1;
			n_s2     <= rrtq_pkg::PROD_W'(plo_s1) + {phi_s1, 32'b0};
			dv_s[0].empty <= empty_s2;
			dv_s[0].pos   <= pos_s2;
			dv_s[0].ovf   <= (n_s2 >= {cfg.tick_den, 31'b0});
			dv_s[0].rem   <= n_s2;
			dv_s[0].quo   <= '0;
		end
	end

	for (genvar j = 1; j <= N; j++) begin : g_div
		localparam int unsigned B = N - j;
		logic [rrtq_pkg::PROD_W-1:0] sh;
		logic ge;
		assign sh = rrtq_pkg::PROD_W'(cfg.tick_den) << B;
		assign ge = (dv_s[j-1].rem >= sh);
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j].empty <= dv_s[j-1].empty;
				dv_s[j].pos   <= dv_s[j-1].pos;
				dv_s[j].ovf   <= dv_s[j-1].ovf;
				dv_s[j].rem   <= ge ? (dv_s[j-1].rem - sh) : dv_s[j-1].rem;
				dv_s[j].quo   <= dv_s[j-1].quo | (rrtq_pkg::IDX_W'(ge) << B);
			end
		end
	end

	// index zero for an empty sequence or a non-positive time, else clamp to the last frame
	always_comb begin
		last = cfg.n_frames - 1'b1;
		if (dv_s[N].empty || !dv_s[N].pos) begin
			idx = '0;
		end else if (dv_s[N].ovf || dv_s[N].quo > last) begin
			idx = last;
		end else begin
			idx = dv_s[N].quo;
		end
		mq_item.valid_res         = !dv_s[N].empty;
		mq_item.frame_index       = idx;
		mq_item.frame_instant     = '0;
		mq_item.instant_saturated = 1'b0;
	end

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (dv_vld_s == $past(dv_vld_s))) else $error("front moved while stalled");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mq_push && mq_item.valid_res) |-> (mq_item.frame_index < cfg.n_frames))
		else $error("frame index past last frame");
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(mq_push && !mq_item.valid_res) |-> (mq_item.frame_index == '0))
		else $error("empty sequence gave an index");
`endif

endmodule

@@ hw/rtl/rrtq_back.sv @@
module rrtq_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rrtq_pkg::cfg_t cfg,
	input  logic           mq_empty,
	input  rrtq_pkg::res_t mq_item,
	output logic           mq_pop,
	output logic           oq_push,
	output rrtq_pkg::res_t oq_item,
	input  logic           oq_full
);

	localparam int unsigned N = rrtq_pkg::BDIV_N;

	logic adv;
	logic vld_s1, vld_s2, vld_s3;
	logic [N:0] dv_vld_s;
	logic empty_s1, empty_s2, empty_s3;
	logic [rrtq_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [62:0] m_s1, pl_s2;
	logic [61:0] ph_s2;
	logic [rrtq_pkg::PROD_W-1:0] n_s3;
	rrtq_pkg::bdiv_t dv_s [0:N];
	logic [31:0] twice, nm;
	logic inc, sat;
	logic [63:0] qq;

	assign adv     = !dv_vld_s[N] || !oq_full;
	assign mq_pop  = adv && !mq_empty;
	assign oq_push = dv_vld_s[N] && !oq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			dv_vld_s <= '0;
		end else if (adv) begin
			vld_s1   <= !mq_empty;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			dv_vld_s <= {dv_vld_s[N-1:0], vld_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			empty_s1 <= !mq_item.valid_res;
			idx_s1   <= mq_item.frame_index;
			m_s1     <= 63'(mq_item.frame_index) * 63'(cfg.tps);
			empty_s2 <= empty_s1;
			idx_s2   <= idx_s1;
			pl_s2    <= 63'(m_s1[31:0]) * 63'(cfg.rate_den);
			ph_s2    <= 62'(m_s1[62:32]) * 62'(cfg.rate_den);
			empty_s3 <= empty_s2;
			idx_s3   <= idx_s2;
			n_s3     <= rrtq_pkg::PROD_W'(pl_s2) + {ph_s2, 32'b0};
			dv_s[0].empty <= empty_s3;
			dv_s[0].idx   <= idx_s3;
			dv_s[0].zero  <= (n_s3 == '0);
			dv_s[0].ovf   <= (n_s3 >= {cfg.rate_num, 63'b0});
			dv_s[0].rem   <= n_s3;
			dv_s[0].quo   <= '0;
		end
	end

	for (genvar j = 1; j <= N; j++) begin : g_div
		localparam int unsigned B = N - j;
		logic [rrtq_pkg::PROD_W-1:0] sh;
		logic ge;
		assign sh = rrtq_pkg::PROD_W'(cfg.rate_num) << B;
		assign ge = (dv_s[j-1].rem >= sh);
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j].empty <= dv_s[j-1].empty;
				dv_s[j].idx   <= dv_s[j-1].idx;
				dv_s[j].zero  <= dv_s[j-1].zero;
				dv_s[j].ovf   <= dv_s[j-1].ovf;
				dv_s[j].rem   <= ge ? (dv_s[j-1].rem - sh) : dv_s[j-1].rem;
				dv_s[j].quo   <= dv_s[j-1].quo | (rrtq_pkg::INST_W'(ge) << B);
			end
		end
	end

	// round half to even, saturate past 63 bits
	always_comb begin
		twice = {dv_s[N].rem[30:0], 1'b0};
		nm    = {1'b0, cfg.rate_num};
		inc   = (twice > nm) || ((twice == nm) && dv_s[N].quo[0]);
		qq    = {1'b0, dv_s[N].quo} + 64'(inc);
		sat   = !dv_s[N].zero && (dv_s[N].ovf || qq[63]);
		oq_item.valid_res         = !dv_s[N].empty;
		oq_item.frame_index       = dv_s[N].idx;
		oq_item.instant_saturated = sat;
		if (dv_s[N].zero) begin
			oq_item.frame_instant = '0;
		end else if (sat) begin
			oq_item.frame_instant = '1;
		end else begin
			oq_item.frame_instant = qq[62:0];
		end
	end

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (dv_vld_s == $past(dv_vld_s))) else $error("back moved while stalled");
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_push && oq_item.instant_saturated) |-> (oq_item.frame_instant == '1))
		else $error("saturated instant not at maximum");
	a_zero_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_push && oq_item.frame_index == '0) |-> (oq_item.frame_instant == '0))
		else $error("first frame instant not zero");
`endif

endmodule

@@ hw/rtl/rational_rate_time_quantizer_top.sv @@
// Pipeline: 3 product stages and 31 divide stages in the front, then the middle queue,
// then 4 product stages and 63 divide stages in the back, then the output queue.
// Throughput: one item per cycle while neither half stalls; both dividers are fully
// unrolled, one quotient bit per stage, and each half stalls on its own behind a
// 4-entry queue.
// Reset: arst_n clears all valid bits and queues at once and loads the register defaults.
module rational_rate_time_quantizer_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [rrtq_pkg::ADDR_W-1:0]           paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [63:0]                    time_ticks,
	input  logic                                  pop,
	output logic                                  empty,
	output logic                                  valid_res,
	output logic [rrtq_pkg::IDX_W-1:0]            frame_index,
	output logic [rrtq_pkg::INST_W-1:0]           frame_instant,
	output logic                                  instant_saturated
);

	logic [rrtq_pkg::NUM_W-1:0] rate_num_q, rate_den_q, n_frames_q;
	logic [rrtq_pkg::TPS_W-1:0] tps_q;
	logic [rrtq_pkg::TD_W-1:0]  tick_den_q;
	rrtq_pkg::cfg_t cfg;
	logic wr_en;

	logic mq_push, mq_full, mq_pop, mq_empty;
	rrtq_pkg::res_t mq_in, mq_out;
	logic oq_push, oq_full;
	rrtq_pkg::res_t oq_in, oq_out;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register file; writes are masked to the register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_num_q <= rrtq_pkg::RST_RATE_NUM;
			rate_den_q <= rrtq_pkg::RST_RATE_DEN;
			tps_q      <= rrtq_pkg::RST_TPS;
			n_frames_q <= rrtq_pkg::RST_NFRAMES;
			tick_den_q <= rrtq_pkg::RST_TICK_DEN;
		end else begin
			// product follows the registers in the next cycle, ahead of any item needing it
			tick_den_q <= 63'(tps_q) * 63'(rate_den_q);
			if (wr_en) begin
				case (paddr[3:2])
					rrtq_pkg::REG_RATE_NUM: rate_num_q <= pwdata[30:0];
					rrtq_pkg::REG_RATE_DEN: rate_den_q <= pwdata[30:0];
					rrtq_pkg::REG_TPS:      tps_q      <= pwdata;
					rrtq_pkg::REG_NFRAMES:  n_frames_q <= pwdata[30:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[3:2])
			rrtq_pkg::REG_RATE_NUM: prdata = {1'b0, rate_num_q};
			rrtq_pkg::REG_RATE_DEN: prdata = {1'b0, rate_den_q};
			rrtq_pkg::REG_TPS:      prdata = tps_q;
			rrtq_pkg::REG_NFRAMES:  prdata = {1'b0, n_frames_q};
			default:                prdata = '0;
		endcase
	end

	assign cfg.rate_num = rate_num_q;
	assign cfg.rate_den = rate_den_q;
	assign cfg.tps      = tps_q;
	assign cfg.n_frames = n_frames_q;
	assign cfg.tick_den = tick_den_q;

	// front: floor(t*num / (tps*den)), zero for a non-positive time, clamped to the last frame
	rrtq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.push       (push),
		.time_ticks (time_ticks),
		.full       (full),
		.mq_push    (mq_push),
		.mq_item    (mq_in),
		.mq_full    (mq_full)
	);

	// hold index beats between the two halves
	rrtq_queue u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.din    (mq_in),
		.full   (mq_full),
		.pop    (mq_pop),
		.dout   (mq_out),
		.empty  (mq_empty)
	);

	// back: round(idx*tps*den / num), ties to even, saturating
	rrtq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.mq_empty (mq_empty),
		.mq_item  (mq_out),
		.mq_pop   (mq_pop),
		.oq_push  (oq_push),
		.oq_item  (oq_in),
		.oq_full  (oq_full)
	);

	// result queue: the back keeps working while the consumer stalls, until the queue fills
	rrtq_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.din    (oq_in),
		.full   (oq_full),
		.pop    (pop),
		.dout   (oq_out),
		.empty  (empty)
	);

	assign valid_res         = oq_out.valid_res;
	assign frame_index       = oq_out.frame_index;
	assign frame_instant     = oq_out.frame_instant;
	assign instant_saturated = oq_out.instant_saturated;

`ifndef SYNTHESIS
	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !valid_res) |-> (frame_index == '0 && frame_instant == '0
			&& !instant_saturated)) else $error("empty sequence result not cleared");
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && instant_saturated) |-> (frame_instant == '1))
		else $error("saturation flag without maximum instant");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && valid_res) |-> (frame_index < n_frames_q))
		else $error("frame index beyond sequence");
`endif

endmodule

@@ dv/rational_rate_time_quantizer_top_test.sv @@
`timescale 1ns / 100ps

module rational_rate_time_quantizer_top_test;

	localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [rrtq_pkg::ADDR_W-1:0]     paddr = '0;
	logic [31:0]                     pwdata = '0;
	logic [31:0]                     prdata;
	logic                            pready;
	logic                            push = 1'b0;
	logic                            full;
	logic [63:0]                     time_ticks = '0;
	logic                            pop = 1'b0;
	logic                            empty;
	logic                            valid_res;
	logic [rrtq_pkg::IDX_W-1:0]      frame_index;
	logic [rrtq_pkg::INST_W-1:0]     frame_instant;
	logic                            instant_saturated;

	// shadow copy of the rate registers
	logic [30:0] cur_num = 31'd24;
	logic [30:0] cur_den = 31'd1;
	logic [31:0] cur_tps = 32'd705600000;
	logic [30:0] cur_count = 31'd0;

	logic [63:0]     time_q[$];     // query times not yet on the bus
	rrtq_pkg::res_t  frame_q[$];    // predicted frames, oldest first
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          fail_seen = 1'b0;

	rational_rate_time_quantizer_top u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .time_ticks(time_ticks),
		.pop(pop), .empty(empty), .valid_res(valid_res), .frame_index(frame_index),
		.frame_instant(frame_instant), .instant_saturated(instant_saturated)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	// Frame covering time t, and that frame's start instant rounded half to even.
	function automatic rrtq_pkg::res_t predict_frame(logic [63:0] t);
		rrtq_pkg::res_t r;
		logic [127:0] prod;
		logic [127:0] quo;
		logic [127:0] rem;
		logic [63:0]  tick_den;
		logic [30:0]  idx;
		r = '0;
		idx = '0;
		if (cur_count == 0)
			return r;
		tick_den = {32'd0, cur_tps} * {33'd0, cur_den};
		if (t != 0 && !t[63] && cur_num != 0) begin
			prod = {64'd0, t} * {97'd0, cur_num};
			// a zero divisor answers all ones: last frame
			quo = (tick_den == 0) ? {128{1'b1}} : prod / {64'd0, tick_den};
			idx = (quo > {97'd0, cur_count - 31'd1}) ? cur_count - 31'd1 : quo[30:0];
		end
		prod = {97'd0, idx} * {64'd0, tick_den};
		if (prod != 0) begin
			if (cur_num == 0) begin
				quo = {128{1'b1}};
			end else begin
				quo = prod / {97'd0, cur_num};
				rem = prod % {97'd0, cur_num};
				// round half to even
				if ((rem << 1) > {97'd0, cur_num} ||
				    ((rem << 1) == {97'd0, cur_num} && quo[0]))
					quo = quo + 1;
			end
			if (quo > {64'd0, MAX63}) begin
				r.frame_instant = MAX63[62:0];
				r.instant_saturated = 1'b1;
			end else begin
				r.frame_instant = quo[62:0];
			end
		end
		r.valid_res = 1'b1;
		r.frame_index = idx;
		return r;
	endfunction

	task automatic add_time(input logic [63:0] t);
		time_q = {time_q, t};
	endtask

	// Driver: advance to the next queued time when the bus is free, idle at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				frame_q = {frame_q, predict_frame(time_ticks)};
			if (!push || !full) begin
				if (time_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					time_ticks <= time_q[0];
					time_q.delete(0);
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: check every popped beat against the oldest prediction.
	always @(posedge clk) begin
		rrtq_pkg::res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (frame_q.size() == 0) begin
					$error("result beat with no prediction pending");
					fail_seen = 1'b1;
				end else begin
					want = frame_q[0];
					frame_q.delete(0);
					if (valid_res !== want.valid_res) begin
						$error("valid_res exp %0d got %0d", want.valid_res, valid_res);
						fail_seen = 1'b1;
					end
					if (frame_index !== want.frame_index) begin
						$error("frame_index exp %0d got %0d", want.frame_index, frame_index);
						fail_seen = 1'b1;
					end
					if (frame_instant !== want.frame_instant) begin
						$error("frame_instant exp %0d got %0d",
							want.frame_instant, frame_instant);
						fail_seen = 1'b1;
					end
					if (instant_saturated !== want.instant_saturated) begin
						$error("instant_saturated exp %0d got %0d",
							want.instant_saturated, instant_saturated);
						fail_seen = 1'b1;
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= rrtq_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rrtq_pkg::REG_RATE_NUM: cur_num = val[30:0];
			rrtq_pkg::REG_RATE_DEN: cur_den = val[30:0];
			rrtq_pkg::REG_TPS:      cur_tps = val;
			rrtq_pkg::REG_NFRAMES:  cur_count = val[30:0];
			default: ;
		endcase
	endtask

	task automatic load_rate(input logic [31:0] num, input logic [31:0] den,
		input logic [31:0] tps, input logic [31:0] count);
		reg_write(rrtq_pkg::REG_RATE_NUM, num);
		reg_write(rrtq_pkg::REG_RATE_DEN, den);
		reg_write(rrtq_pkg::REG_TPS, tps);
		reg_write(rrtq_pkg::REG_NFRAMES, count);
	endtask

	// Hold until every time is accepted and every frame is back, then let the pipe settle.
	task automatic drain_all();
		while (time_q.size() != 0 || push || frame_q.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_reg(input logic [31:0] top);
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'd1;
			2: return top;
			3: return $urandom_range(1, 100);
			default: return $urandom & top;
		endcase
	endfunction

	// Mostly times that land inside the sequence, the rest anywhere.
	function automatic logic [63:0] pick_time();
		logic [127:0] span;
		logic [63:0]  raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(9))
			0: return raw;
			1: return -(raw >> $urandom_range(63));
			2: return 64'd0;
			3: return ($urandom_range(1)) ? MAX63 : MIN64;
			default: begin
				if (cur_num == 0)
					return raw >> $urandom_range(63);
				span = ({96'd0, cur_tps} * {97'd0, cur_den} * {97'd0, cur_count + 31'd1})
					/ {97'd0, cur_num};
				if (span > {64'd0, MAX63} || span == 0)
					return raw >> $urandom_range(1, 63);
				return raw % (span[63:0] + 64'd1);
			end
		endcase
	endfunction

	initial begin
		int unsigned modes[4][2] = '{'{0, 0}, '{80, 0}, '{0, 80}, '{11, 11}};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty sequence at reset defaults
		add_time(64'd12345);
		add_time(MAX63);
		drain_all();

		// film rate at flick resolution: boundaries, negatives, extremes
		load_rate(32'd24, 32'd1, 32'd705600000, 32'd100);
		add_time(64'd0);
		add_time(64'hFFFF_FFFF_FFFF_FFFF);
		add_time(MIN64);
		add_time(MAX63);
		add_time(64'd1);
		add_time(64'd29400000);
		add_time(64'd29399999);
		add_time(64'd29400001 * 64'd50);
		drain_all();

		// rate 2/3 at 1 tick per second: instant ties
		load_rate(32'd2, 32'd3, 32'd1, 32'h7FFF_FFFF);
		add_time(64'd3);
		add_time(64'd5);
		add_time(64'd9);
		drain_all();

		// zero divisors and zero numerator
		load_rate(32'd7, 32'd1, 32'd0, 32'd9);
		add_time(64'd1);
		add_time(MAX63);
		drain_all();
		reg_write(rrtq_pkg::REG_TPS, 32'd1000);
		reg_write(rrtq_pkg::REG_RATE_DEN, 32'd0);
		add_time(64'd5);
		drain_all();
		load_rate(32'd0, 32'd1, 32'd1000, 32'd9);
		add_time(64'd5000);
		drain_all();

		// widest products toward the saturation edge
		load_rate(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		add_time(MAX63);
		add_time(MAX63 - 64'd1);
		drain_all();
		reg_write(rrtq_pkg::REG_RATE_NUM, 32'd1);
		add_time(MAX63);
		drain_all();

		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = modes[ph % 4][0];
			recv_stall_pct = modes[ph % 4][1];
			if (ph == 0)
				load_rate(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
			else if (ph == 1)
				load_rate(32'd1, 32'd1, 32'd1, 32'd1);
			else
				load_rate(pick_reg(32'h7FFF_FFFF), pick_reg(32'h7FFF_FFFF),
					pick_reg(32'hFFFF_FFFF), pick_reg(32'h7FFF_FFFF));
			for (int n = 0; n < 215; n++)
				add_time(pick_time());
			drain_all();
		end

		if (!fail_seen && frame_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
